[hdl/bsa_pkg.sv]
// bsa_pkg: shared types and constants of the beam stiffness assembly block
// holds opcodes, status codes, term selects and the controller/datapath structs
// no dependencies
package bsa_pkg;

   typedef enum logic [1:0] {
      OP_SET_COORD = 2'd0,
      OP_ADD_BAR   = 2'd1,
      OP_READ      = 2'd2,
      OP_CLEAR     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_LEN = 2'd1,
      ST_RANGE    = 2'd2
   } status_type;

   // 12EI/L^3, 6EI/L^2, 4EI/L, 2EI/L
   typedef enum logic [1:0] {
      TERM_A = 2'd0,
      TERM_B = 2'd1,
      TERM_C = 2'd2,
      TERM_D = 2'd3
   } term_type;

   typedef struct packed {
      logic     neg;
      term_type sel;
   } block_term_type;

   // 4x4 element block, row-major
   localparam block_term_type BLOCK_TERM [16] = '{
      '{1'b0, TERM_A}, '{1'b0, TERM_B}, '{1'b1, TERM_A}, '{1'b0, TERM_B},
      '{1'b0, TERM_B}, '{1'b0, TERM_C}, '{1'b1, TERM_B}, '{1'b0, TERM_D},
      '{1'b1, TERM_A}, '{1'b1, TERM_B}, '{1'b0, TERM_A}, '{1'b1, TERM_B},
      '{1'b0, TERM_B}, '{1'b0, TERM_D}, '{1'b1, TERM_B}, '{1'b0, TERM_C}
   };

   localparam logic [4:0]  ACTIVE_RESET = 5'd16;
   localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic     req_load;
      logic     coord_wr;
      logic     coord_rd;
      logic     coord_sel_e;
      logic     cs_load;
      logic     len_load;
      logic     num_load;
      logic     div_reload;
      logic     div_step;
      logic     term_store;
      logic     mat_rd_rc;
      logic     mat_rd_ent;
      logic     mat_wr_ent;
      logic     value_load;
      logic     clr_init;
      logic     clr_step;
      term_type term;
      logic [3:0] ent;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   node_bad;
      logic   rc_bad;
      logic   len_zero;
      logic   div_done;
      logic   clr_done;
   } stat_type;

endpackage

[hdl/beam_stiffness_assembly.sv]
// beam_stiffness_assembly: top level, controller plus datapath
// from accept to the result beat: set coordinate and range errors pass only the decode;
// a read adds a matrix read, a zero-length bar two coordinate reads and a length check,
// a bar six 128-step bit-serial divisions and 16 read-modify-writes after those, and a
// clear a sweep of all (2*MAX_NODES rounded to a power of two)^2 entries; one item at a time,
// busy high through the result strobe; after reset the matrix is swept to zero, busy meanwhile
module beam_stiffness_assembly #(
   parameter int MAX_NODES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic [3:0]         req_start_node,
   input  logic [3:0]         req_end_node,
   input  logic signed [31:0] req_coord_value,
   input  logic [31:0]        req_modulus,
   input  logic [31:0]        req_inertia,
   input  logic [4:0]         req_row_index,
   input  logic [4:0]         req_col_index,
   output logic               rsp_valid,
   output logic signed [63:0] rsp_read_value,
   output logic [1:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [4:0]         csr_active_nodes
);

   bsa_pkg::cmd_type  cmd;
   bsa_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   bsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .stat       (stat),
      .cmd        (cmd),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status)
   );

   bsa_dp #(.MAX_NODES(MAX_NODES)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_op           (req_op),
      .req_start_node   (req_start_node),
      .req_end_node     (req_end_node),
      .req_coord_value  (req_coord_value),
      .req_modulus      (req_modulus),
      .req_inertia      (req_inertia),
      .req_row_index    (req_row_index),
      .req_col_index    (req_col_index),
      .csr_valid        (csr_valid),
      .csr_active_nodes (csr_active_nodes),
      .rsp_read_value   (rsp_read_value)
   );

endmodule

[hdl/bsa_dp.sv]
// bsa_dp: datapath of the beam stiffness assembly block
// request latch, coordinate store, bit-serial divider, term registers, matrix memory
// depends on bsa_pkg
module bsa_dp #(
   parameter int MAX_NODES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  bsa_pkg::cmd_type    cmd,
   output bsa_pkg::stat_type   stat,
   input  logic [1:0]          req_op,
   input  logic [3:0]          req_start_node,
   input  logic [3:0]          req_end_node,
   input  logic signed [31:0]  req_coord_value,
   input  logic [31:0]         req_modulus,
   input  logic [31:0]         req_inertia,
   input  logic [4:0]          req_row_index,
   input  logic [4:0]          req_col_index,
   input  logic                csr_valid,
   input  logic [4:0]          csr_active_nodes,
   output logic signed [63:0]  rsp_read_value
);

   localparam int NW    = $clog2(MAX_NODES);
   localparam int DW    = NW + 1;
   localparam int MW    = 2 * DW;
   localparam int DEPTH = 1 << MW;
   localparam logic [6:0] MAXN = 7'(MAX_NODES);

   bsa_pkg::op_type op_ff;
   logic [3:0]   s_ff, e_ff;
   logic [31:0]  coord_ff, mod_ff, inr_ff;
   logic [4:0]   row_ff, col_ff;
   logic [4:0]   active_ff;
   logic [63:0]  ei_ff;

   logic [31:0]  coord_mem [MAX_NODES];
   logic [31:0]  coord_q_ff, cs_ff, len_ff;

   logic [127:0] dvd_ff, dvd_in;
   logic [31:0]  rem_ff, rem_in;
   logic [6:0]   cnt_ff;
   logic [63:0]  ta_ff, tb_ff, tc_ff, td_ff;

   logic [63:0]  mat_mem [DEPTH];
   logic [63:0]  mat_q_ff, value_ff;
   logic [MW-1:0] clr_cnt_ff;

   // bounds
   logic [6:0] nb;
   assign nb = (7'(active_ff) < MAXN) ? 7'(active_ff) : MAXN;

   logic [NW+3:0] s_ext, e_ext;
   logic [NW-1:0] s_idx, e_idx;
   assign s_ext = {{NW{1'b0}}, s_ff};
   assign e_ext = {{NW{1'b0}}, e_ff};
   assign s_idx = s_ext[NW-1:0];
   assign e_idx = e_ext[NW-1:0];

   logic [DW+4:0] row_ext, col_ext;
   assign row_ext = {{DW{1'b0}}, row_ff};
   assign col_ext = {{DW{1'b0}}, col_ff};

   // element block addresses
   logic [1:0]    bi, bj;
   logic [DW-1:0] dof_r, dof_c;
   logic [MW-1:0] ent_addr, rc_addr;
   assign bi    = cmd.ent[3:2];
   assign bj    = cmd.ent[1:0];
   assign dof_r = {bi[1] ? e_idx : s_idx, bi[0]};
   assign dof_c = {bj[1] ? e_idx : s_idx, bj[0]};
   assign ent_addr = {dof_r, dof_c};
   assign rc_addr  = {row_ext[DW-1:0], col_ext[DW-1:0]};

   // length
   logic signed [32:0] diff;
   logic [32:0] adiff;
   assign diff  = 33'(signed'(coord_q_ff)) - 33'(signed'(cs_ff));
   assign adiff = diff[32] ? 33'(-diff) : 33'(diff);

   // numerators k*EI*2^(16n)
   logic [127:0] ei_w, num;
   assign ei_w = {64'd0, ei_ff};
   always_comb begin
      case (cmd.term)
         bsa_pkg::TERM_A: num = ((ei_w << 3) + (ei_w << 2)) << 48;
         bsa_pkg::TERM_B: num = ((ei_w << 2) + (ei_w << 1)) << 32;
         default:         num = (ei_w << 2) << 16;
      endcase
   end

   // one quotient bit per step
   logic [32:0] trial;
   logic        qbit;
   assign trial = {rem_ff, dvd_ff[127]};
   assign qbit  = trial >= {1'b0, len_ff};
   assign rem_in = qbit ? 32'(trial - {1'b0, len_ff}) : trial[31:0];
   assign dvd_in = {dvd_ff[126:0], qbit};

   logic [127:0] dvd_half;
   logic [63:0]  sat_q, sat_half;
   assign dvd_half = dvd_ff >> 1;
   assign sat_q    = (|dvd_ff[127:63])   ? bsa_pkg::SAT_MAX : dvd_ff[63:0];
   assign sat_half = (|dvd_half[127:63]) ? bsa_pkg::SAT_MAX : dvd_half[63:0];

   // accumulate
   bsa_pkg::block_term_type bt;
   logic [63:0] tsel, tadd;
   logic [64:0] sum;
   logic [63:0] acc;
   assign bt = bsa_pkg::BLOCK_TERM[cmd.ent];
   always_comb begin
      case (bt.sel)
         bsa_pkg::TERM_A: tsel = ta_ff;
         bsa_pkg::TERM_B: tsel = tb_ff;
         bsa_pkg::TERM_C: tsel = tc_ff;
         default:         tsel = td_ff;
      endcase
   end
   assign tadd = bt.neg ? 64'(-tsel) : tsel;
   assign sum  = {mat_q_ff[63], mat_q_ff} + {tadd[63], tadd};
   assign acc  = (sum[64] != sum[63]) ? (sum[64] ? bsa_pkg::SAT_MIN : bsa_pkg::SAT_MAX)
                                      : sum[63:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= bsa_pkg::ACTIVE_RESET;
         clr_cnt_ff <= '0;
      end else begin
         if (csr_valid) active_ff <= csr_active_nodes;
         if (cmd.clr_init) clr_cnt_ff <= '0;
         else if (cmd.clr_step) clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         op_ff    <= bsa_pkg::op_type'(req_op);
         s_ff     <= req_start_node;
         e_ff     <= req_end_node;
         coord_ff <= req_coord_value;
         mod_ff   <= req_modulus;
         inr_ff   <= req_inertia;
         row_ff   <= req_row_index;
         col_ff   <= req_col_index;
      end
      ei_ff <= mod_ff * inr_ff;
      if (cmd.coord_wr) coord_mem[s_idx] <= coord_ff;
      if (cmd.coord_rd) coord_q_ff <= coord_mem[cmd.coord_sel_e ? e_idx : s_idx];
      if (cmd.cs_load) cs_ff <= coord_q_ff;
      if (cmd.len_load) len_ff <= adiff[31:0];
      if (cmd.num_load) begin
         dvd_ff <= num;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_reload) begin
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.term_store) begin
         case (cmd.term)
            bsa_pkg::TERM_A: ta_ff <= sat_q;
            bsa_pkg::TERM_B: tb_ff <= sat_q;
            default: begin
               tc_ff <= sat_q;
               td_ff <= sat_half;
            end
         endcase
      end
      if (cmd.mat_rd_rc) mat_q_ff <= mat_mem[rc_addr];
      else if (cmd.mat_rd_ent) mat_q_ff <= mat_mem[ent_addr];
      if (cmd.clr_step) mat_mem[clr_cnt_ff] <= '0;
      else if (cmd.mat_wr_ent) mat_mem[ent_addr] <= acc;
      if (cmd.req_load) value_ff <= '0;
      else if (cmd.value_load) value_ff <= mat_q_ff;
   end

   assign stat.op       = op_ff;
   assign stat.node_bad = (7'(s_ff) >= nb) || ((op_ff == bsa_pkg::OP_ADD_BAR) && (7'(e_ff) >= nb));
   assign stat.rc_bad   = (8'(row_ff) >= {nb, 1'b0}) || (8'(col_ff) >= {nb, 1'b0});
   assign stat.len_zero = (len_ff == '0);
   assign stat.div_done = (cnt_ff == 7'd127);
   assign stat.clr_done = &clr_cnt_ff;

   assign rsp_read_value = value_ff;

endmodule

[hdl/bsa_ctrl.sv]
// bsa_ctrl: sequencing state machine of the beam stiffness assembly block
// drives datapath commands, owns status code and result strobe
// depends on bsa_pkg
module bsa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bsa_pkg::stat_type stat,
   output bsa_pkg::cmd_type  cmd,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status
);

   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_DECODE   = 13'b0000000000010,
      S_CRD_E    = 13'b0000000000100,
      S_LEN      = 13'b0000000001000,
      S_CHECK    = 13'b0000000010000,
      S_LOAD     = 13'b0000000100000,
      S_DIV      = 13'b0000001000000,
      S_DIV_NEXT = 13'b0000010000000,
      S_MRD      = 13'b0000100000000,
      S_MWR      = 13'b0001000000000,
      S_RD_WAIT  = 13'b0010000000000,
      S_CLEAR    = 13'b0100000000000,
      S_RESP     = 13'b1000000000000
   } state_type;

   state_type            state_ff, state_in;
   bsa_pkg::status_type  status_ff, status_in;
   bsa_pkg::term_type    term_ff, term_in;
   logic [1:0]           pass_ff, pass_in;
   logic [3:0]           ent_ff, ent_in;
   logic                 clr_resp_ff, clr_resp_in;
   logic                 last_pass;

   assign last_pass = (pass_ff == 2'(2'd2 - term_ff));

   always_comb begin
      state_in    = state_ff;
      status_in   = status_ff;
      term_in     = term_ff;
      pass_in     = pass_ff;
      ent_in      = ent_ff;
      clr_resp_in = clr_resp_ff;
      cmd         = '0;
      cmd.term    = term_ff;
      cmd.ent     = ent_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.req_load = 1'b1;
               status_in    = bsa_pkg::ST_OK;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.op)
               bsa_pkg::OP_SET_COORD: begin
                  if (stat.node_bad) status_in = bsa_pkg::ST_RANGE;
                  else cmd.coord_wr = 1'b1;
                  state_in = S_RESP;
               end
               bsa_pkg::OP_ADD_BAR: begin
                  if (stat.node_bad) begin
                     status_in = bsa_pkg::ST_RANGE;
                     state_in  = S_RESP;
                  end else begin
                     cmd.coord_rd = 1'b1;
                     state_in     = S_CRD_E;
                  end
               end
               bsa_pkg::OP_READ: begin
                  if (stat.rc_bad) begin
                     status_in = bsa_pkg::ST_RANGE;
                     state_in  = S_RESP;
                  end else begin
                     cmd.mat_rd_rc = 1'b1;
                     state_in      = S_RD_WAIT;
                  end
               end
               default: begin
                  cmd.clr_init = 1'b1;
                  clr_resp_in  = 1'b1;
                  state_in     = S_CLEAR;
               end
            endcase
         end
         S_CRD_E: begin
            cmd.cs_load     = 1'b1;
            cmd.coord_rd    = 1'b1;
            cmd.coord_sel_e = 1'b1;
            state_in        = S_LEN;
         end
         S_LEN: begin
            cmd.len_load = 1'b1;
            state_in     = S_CHECK;
         end
         S_CHECK: begin
            if (stat.len_zero) begin
               status_in = bsa_pkg::ST_ZERO_LEN;
               state_in  = S_RESP;
            end else begin
               term_in  = bsa_pkg::TERM_A;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.num_load = 1'b1;
            pass_in      = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = S_DIV_NEXT;
         end
         S_DIV_NEXT: begin
            if (last_pass) begin
               cmd.term_store = 1'b1;
               if (term_ff == bsa_pkg::TERM_C) begin
                  ent_in   = '0;
                  state_in = S_MRD;
               end else begin
                  term_in  = bsa_pkg::term_type'(term_ff + 2'd1);
                  state_in = S_LOAD;
               end
            end else begin
               cmd.div_reload = 1'b1;
               pass_in        = pass_ff + 2'd1;
               state_in       = S_DIV;
            end
         end
         S_MRD: begin
            cmd.mat_rd_ent = 1'b1;
            state_in       = S_MWR;
         end
         S_MWR: begin
            cmd.mat_wr_ent = 1'b1;
            ent_in         = ent_ff + 4'd1;
            state_in       = (ent_ff == 4'd15) ? S_RESP : S_MRD;
         end
         S_RD_WAIT: begin
            cmd.value_load = 1'b1;
            state_in       = S_RESP;
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_done) state_in = clr_resp_ff ? S_RESP : S_IDLE;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         status_ff   <= bsa_pkg::ST_OK;
         term_ff     <= bsa_pkg::TERM_A;
         pass_ff     <= '0;
         ent_ff      <= '0;
         clr_resp_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         status_ff   <= status_in;
         term_ff     <= term_in;
         pass_ff     <= pass_in;
         ent_ff      <= ent_in;
         clr_resp_ff <= clr_resp_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = (state_ff == S_RESP);
   assign rsp_status = status_ff;

endmodule
